>>> rtl/hfcm_pkg.sv
`default_nettype none
package hfcm_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FIELD_COORD_W  = 10;
  localparam int RADIUS_SQ_W    = 22;
  localparam int HUE_SPAN_W     = 9;
  localparam int INTENSITY_W    = 8;
  localparam int CHAN_W         = 8;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;
  localparam int NUM_STAGES     = 7;

  localparam int PROD_W = INTENSITY_W + HUE_SPAN_W;
  localparam int HUE_W  = PROD_W + 1;
  localparam int FRAC_W = 14;
  localparam int SUM_W  = 22;
  localparam int TQ_W   = SUM_W - 10;

  localparam logic [HUE_W-1:0]  FULL_Q    = HUE_W'(92160);
  localparam logic [HUE_W-1:0]  SECTOR_Q  = HUE_W'(15360);
  localparam logic [HUE_W-1:0]  HUE_ROUND = HUE_W'(127);
  localparam logic [SUM_W-1:0]  HALF_Q    = SUM_W'(7680);
  localparam logic [8:0]        RECIP_255 = 9'd257;
  localparam logic [12:0]       RECIP_15  = 13'd4369;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

  localparam logic [CHAN_W-1:0] MASK_RED   = 8'd64;
  localparam logic [CHAN_W-1:0] MASK_GREEN = 8'd64;
  localparam logic [CHAN_W-1:0] MASK_BLUE  = 8'd255;

  typedef enum logic [2:0] {
    REG_RING_CX   = 3'd0,
    REG_RING_CY   = 3'd1,
    REG_RING_R2   = 3'd2,
    REG_BOX_LEFT  = 3'd3,
    REG_BOX_BOT   = 3'd4,
    REG_BOX_WIDTH = 3'd5,
    REG_BOX_HGT   = 3'd6,
    REG_HUE_SPAN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] ring_cx;
    logic [FIELD_COORD_W-1:0] ring_cy;
    logic [RADIUS_SQ_W-1:0]   ring_r2;
    logic [FIELD_COORD_W-1:0] box_left;
    logic [FIELD_COORD_W-1:0] box_bottom;
    logic [FIELD_COORD_W-1:0] box_width;
    logic [FIELD_COORD_W-1:0] box_height;
    logic [HUE_SPAN_W-1:0]    hue_span;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ring_cx:    10'd250,
    ring_cy:    10'd250,
    ring_r2:    22'd35941,
    box_left:   10'd479,
    box_bottom: 10'd63,
    box_width:  10'd42,
    box_height: 10'd375,
    hue_span:   9'd220
  };

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t color;
    logic masked;
  } pix_out_t;

  function automatic logic [HUE_W-1:0] sector_base(input logic [2:0] sector);
    logic [HUE_W-1:0] base;
    unique case (sector)
      3'd0:    base = '0;
      3'd1:    base = SECTOR_Q;
      3'd2:    base = HUE_W'(30720);
      3'd3:    base = HUE_W'(46080);
      3'd4:    base = HUE_W'(61440);
      default: base = HUE_W'(76800);
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hfcm_if.sv
`default_nettype none
interface hfcm_pix_if #(
  parameter int COORD_BITS = hfcm_pkg::COORD_BITS_DEF
);
  import hfcm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS-1:0]  pixel_x;
  logic [COORD_BITS-1:0]  pixel_y;
  logic [INTENSITY_W-1:0] intensity;

  modport source (output valid, output pixel_x, output pixel_y, output intensity,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input intensity,
                output ready);
endinterface

interface hfcm_rgb_if;
  import hfcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              masked;

  modport source (output valid, output red, output green, output blue, output masked,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input masked,
                output ready);
endinterface
`default_nettype wire

>>> rtl/hfcm_regs.sv
`default_nettype none
module hfcm_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hfcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [hfcm_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [hfcm_pkg::CFG_DATA_W-1:0] prdata,
  output      hfcm_pkg::cfg_t                 cfg
);
  import hfcm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_RING_CX:   cfg_nxt.ring_cx    = pwdata[FIELD_COORD_W-1:0];
        REG_RING_CY:   cfg_nxt.ring_cy    = pwdata[FIELD_COORD_W-1:0];
        REG_RING_R2:   cfg_nxt.ring_r2    = pwdata[RADIUS_SQ_W-1:0];
        REG_BOX_LEFT:  cfg_nxt.box_left   = pwdata[FIELD_COORD_W-1:0];
        REG_BOX_BOT:   cfg_nxt.box_bottom = pwdata[FIELD_COORD_W-1:0];
        REG_BOX_WIDTH: cfg_nxt.box_width  = pwdata[FIELD_COORD_W-1:0];
        REG_BOX_HGT:   cfg_nxt.box_height = pwdata[FIELD_COORD_W-1:0];
        REG_HUE_SPAN:  cfg_nxt.hue_span   = pwdata[HUE_SPAN_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_RING_CX:   prdata = CFG_DATA_W'(cfg_r.ring_cx);
      REG_RING_CY:   prdata = CFG_DATA_W'(cfg_r.ring_cy);
      REG_RING_R2:   prdata = CFG_DATA_W'(cfg_r.ring_r2);
      REG_BOX_LEFT:  prdata = CFG_DATA_W'(cfg_r.box_left);
      REG_BOX_BOT:   prdata = CFG_DATA_W'(cfg_r.box_bottom);
      REG_BOX_WIDTH: prdata = CFG_DATA_W'(cfg_r.box_width);
      REG_BOX_HGT:   prdata = CFG_DATA_W'(cfg_r.box_height);
      REG_HUE_SPAN:  prdata = CFG_DATA_W'(cfg_r.hue_span);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/hfcm_hue.sv
`default_nettype none
module hfcm_hue (
  input  wire logic                            clk,
  input  wire logic [5:0]                      en,
  input  wire logic [hfcm_pkg::HUE_SPAN_W-1:0]  hue_span,
  input  wire logic [hfcm_pkg::INTENSITY_W-1:0] intensity,
  output      hfcm_pkg::rgb_t                  color
);
  import hfcm_pkg::*;

  // stage 0: scaled product
  logic [PROD_W-1:0] p0_r, p0_nxt;
  // stage 1: coarse quotient by 255
  logic [PROD_W-1:0] p1_r;
  logic [HUE_W-1:0]  v1_r, v1_nxt;
  logic [8:0]        q1_r, q1_nxt;
  logic [HUE_W+8:0]  v1_prod;
  // stage 2: corrected hue
  logic [HUE_W-1:0]  hue2_r, hue2_nxt;
  logic [HUE_W-1:0]  rem2;
  // stage 3: sector and fraction
  logic [2:0]        sec3_r, sec3_nxt;
  logic [FRAC_W-1:0] frac3_r, frac3_nxt;
  logic [HUE_W-1:0]  hw3, fr3;
  // stage 4: scaled rise and fall
  logic [2:0]        sec4_r;
  logic [TQ_W-1:0]   tr4_r, tr4_nxt, tf4_r, tf4_nxt;
  logic [SUM_W-1:0]  sr4, sf4;
  logic [FRAC_W:0]   ff4;
  // stage 5: coarse quotient by 15
  logic [2:0]        sec5_r;
  logic [TQ_W-1:0]   tr5_r, tf5_r;
  logic [CHAN_W-1:0] qr5_r, qr5_nxt, qf5_r, qf5_nxt;
  logic [TQ_W+12:0]  pr5, pf5;
  // output of stage 5
  logic [TQ_W-1:0]   remr, remf;
  logic [CHAN_W-1:0] rise, fall;

  assign p0_nxt = PROD_W'(CHAN_MAX - intensity) * PROD_W'(hue_span);

  assign v1_nxt  = HUE_W'(p0_r) + HUE_ROUND;
  assign v1_prod = v1_nxt * RECIP_255;
  assign q1_nxt  = v1_prod[HUE_W+6:16];

  always_comb begin
    rem2     = v1_r - HUE_W'(q1_r) * HUE_W'(9'd255);
    hue2_nxt = HUE_W'(p1_r) + HUE_W'(q1_r) + HUE_W'(rem2 >= HUE_W'(255));
  end

  always_comb begin
    hw3 = (hue2_r >= FULL_Q) ? hue2_r - FULL_Q : hue2_r;
    priority if (hw3 >= sector_base(3'd5)) begin
      sec3_nxt = 3'd5;
    end else if (hw3 >= sector_base(3'd4)) begin
      sec3_nxt = 3'd4;
    end else if (hw3 >= sector_base(3'd3)) begin
      sec3_nxt = 3'd3;
    end else if (hw3 >= sector_base(3'd2)) begin
      sec3_nxt = 3'd2;
    end else if (hw3 >= sector_base(3'd1)) begin
      sec3_nxt = 3'd1;
    end else begin
      sec3_nxt = 3'd0;
    end
    fr3       = hw3 - sector_base(sec3_nxt);
    frac3_nxt = fr3[FRAC_W-1:0];
  end

  always_comb begin
    ff4     = (FRAC_W+1)'(SECTOR_Q) - (FRAC_W+1)'(frac3_r);
    sr4     = (SUM_W'(frac3_r) << 8) - SUM_W'(frac3_r) + HALF_Q;
    sf4     = (SUM_W'(ff4) << 8) - SUM_W'(ff4) + HALF_Q;
    tr4_nxt = sr4[SUM_W-1:10];
    tf4_nxt = sf4[SUM_W-1:10];
  end

  assign pr5     = tr4_r * RECIP_15;
  assign pf5     = tf4_r * RECIP_15;
  assign qr5_nxt = pr5[23:16];
  assign qf5_nxt = pf5[23:16];

  always_comb begin
    remr = tr5_r - TQ_W'(qr5_r) * TQ_W'(4'd15);
    remf = tf5_r - TQ_W'(qf5_r) * TQ_W'(4'd15);
    rise = qr5_r + CHAN_W'(remr >= TQ_W'(15));
    fall = qf5_r + CHAN_W'(remf >= TQ_W'(15));
    unique case (sec5_r)
      3'd0:    color = '{red: CHAN_MAX, green: rise,     blue: '0};
      3'd1:    color = '{red: fall,     green: CHAN_MAX, blue: '0};
      3'd2:    color = '{red: '0,       green: CHAN_MAX, blue: rise};
      3'd3:    color = '{red: '0,       green: fall,     blue: CHAN_MAX};
      3'd4:    color = '{red: rise,     green: '0,       blue: CHAN_MAX};
      default: color = '{red: CHAN_MAX, green: '0,       blue: fall};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_r <= p0_nxt;
    end
    if (en[1]) begin
      p1_r <= p0_r;
      v1_r <= v1_nxt;
      q1_r <= q1_nxt;
    end
    if (en[2]) begin
      hue2_r <= hue2_nxt;
    end
    if (en[3]) begin
      sec3_r  <= sec3_nxt;
      frac3_r <= frac3_nxt;
    end
    if (en[4]) begin
      sec4_r <= sec3_r;
      tr4_r  <= tr4_nxt;
      tf4_r  <= tf4_nxt;
    end
    if (en[5]) begin
      sec5_r <= sec4_r;
      tr5_r  <= tr4_r;
      tf5_r  <= tf4_r;
      qr5_r  <= qr5_nxt;
      qf5_r  <= qf5_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hfcm_mask.sv
`default_nettype none
module hfcm_mask #(
  parameter int COORD_BITS = hfcm_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic [5:0]            en,
  input  wire hfcm_pkg::cfg_t        cfg,
  input  wire logic [COORD_BITS-1:0] pixel_x,
  input  wire logic [COORD_BITS-1:0] pixel_y,
  output      logic                  masked
);
  import hfcm_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = ((CW > FIELD_COORD_W) ? CW : FIELD_COORD_W) + 1;
  localparam int SW = 2 * CW;
  localparam int DW = ((SW + 1 > RADIUS_SQ_W) ? SW + 1 : RADIUS_SQ_W);

  logic signed [CW:0]    dx0_r, dx0_nxt, dy0_r, dy0_nxt;
  logic                  ob0_r, ob0_nxt;
  logic signed [SW+1:0]  dxp, dyp;
  logic [SW-1:0]         dx1_r, dy1_r;
  logic                  ob1_r;
  logic [DW-1:0]         d2;
  logic                  m2_r, m2_nxt;
  logic [2:0]            dly_r;
  logic [CW-1:0]         cx, cy, left, bottom;
  logic [EW-1:0]         right_e, top_e;

  always_comb begin
    cx      = CW'(cfg.ring_cx);
    cy      = CW'(cfg.ring_cy);
    left    = CW'(cfg.box_left);
    bottom  = CW'(cfg.box_bottom);
    dx0_nxt = $signed({1'b0, pixel_x}) - $signed({1'b0, cx});
    dy0_nxt = $signed({1'b0, pixel_y}) - $signed({1'b0, cy});
    right_e = EW'(left) + EW'(cfg.box_width);
    top_e   = EW'(bottom) + EW'(cfg.box_height);
    ob0_nxt = (pixel_x < left) || (EW'(pixel_x) > right_e) ||
              (pixel_y < bottom) || (EW'(pixel_y) > top_e);
  end

  assign dxp = dx0_r * dx0_r;
  assign dyp = dy0_r * dy0_r;

  assign d2     = DW'(dx1_r) + DW'(dy1_r);
  assign m2_nxt = (d2 > DW'(cfg.ring_r2)) && ob1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx0_r <= dx0_nxt;
      dy0_r <= dy0_nxt;
      ob0_r <= ob0_nxt;
    end
    if (en[1]) begin
      dx1_r <= dxp[SW-1:0];
      dy1_r <= dyp[SW-1:0];
      ob1_r <= ob0_r;
    end
    if (en[2]) begin
      m2_r <= m2_nxt;
    end
    if (en[3]) begin
      dly_r[0] <= m2_r;
    end
    if (en[4]) begin
      dly_r[1] <= dly_r[0];
    end
    if (en[5]) begin
      dly_r[2] <= dly_r[1];
    end
  end

  assign masked = dly_r[2];

endmodule
`default_nettype wire

>>> rtl/heatmap_false_color_mask_unit.sv
`default_nettype none
// False-color heat map with mask. Each pixel transfer (coordinate plus 8-bit
// intensity) yields one RGB result: intensity maps to hue (255 - intensity) *
// hue_span / 255 degrees, converted at full saturation and value; pixels
// outside both the ring circle and the side rectangle come out as 64,64,255
// with masked set. One pixel per clock is accepted while the output is not
// held back; each result passes through the seven register stages before it
// is offered. Back-pressure on the output stalls only filled stages, so
// bubbles are squeezed out. Registers (APB, 32-bit, byte address 4*i):
// ring_center_x, ring_center_y, ring_radius_squared, box_left, box_bottom,
// box_width, box_height, hue_span.
// Write them only while the pipeline is empty.
module heatmap_false_color_mask_unit #(
  parameter int COORD_BITS = hfcm_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hfcm_pix_if.sink                             in_ch,
  hfcm_rgb_if.source                           out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [hfcm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [hfcm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [hfcm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);
  import hfcm_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  cfg_t                  cfg;
  rgb_t                  color;
  logic                  masked;
  logic [LAST:0]         vld_r, vld_nxt;
  logic [LAST:0]         en;
  pix_out_t              out_r, out_nxt;

  hfcm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  hfcm_hue u_hue (
    .clk       (clk),
    .en        (en[LAST-1:0]),
    .hue_span  (cfg.hue_span),
    .intensity (in_ch.intensity),
    .color     (color)
  );

  hfcm_mask #(
    .COORD_BITS (COORD_BITS)
  ) u_mask (
    .clk     (clk),
    .en      (en[LAST-1:0]),
    .cfg     (cfg),
    .pixel_x (in_ch.pixel_x),
    .pixel_y (in_ch.pixel_y),
    .masked  (masked)
  );

  always_comb begin
    en[LAST] = !vld_r[LAST] || out_ch.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_comb begin
    out_nxt.masked = masked;
    if (masked) begin
      out_nxt.color = '{red: MASK_RED, green: MASK_GREEN, blue: MASK_BLUE};
    end else begin
      out_nxt.color = color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_r <= out_nxt;
    end
  end

  assign in_ch.ready   = en[0];
  assign out_ch.valid  = vld_r[LAST];
  assign out_ch.red    = out_r.color.red;
  assign out_ch.green  = out_r.color.green;
  assign out_ch.blue   = out_r.color.blue;
  assign out_ch.masked = out_r.masked;
  assign cfg_pready    = 1'b1;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[LAST] |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST-1] && en[LAST]) |=> vld_r[LAST])
    else $error("result lost entering output stage");

  a_mask_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.masked) |->
      (out_ch.red == MASK_RED && out_ch.green == MASK_GREEN && out_ch.blue == MASK_BLUE))
    else $error("masked pixel without mask color");

endmodule
`default_nettype wire

>>> bench/heatmap_false_color_mask_unit_tb.sv
`timescale 1ns / 1ps

module heatmap_false_color_mask_unit_tb;
  import hfcm_pkg::*;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int NUM_REGS      = 8;
  localparam int HUE_SECTOR    = 60 * 256;
  localparam int HUE_FULL      = 360 * 256;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_PIXELS  = 104;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int NO_IDLE_PHASE = 3;
  localparam int HOLD_PHASE    = 5;

  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [INTENSITY_W-1:0] inten;
  } pix_item_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  hfcm_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
  hfcm_rgb_if rgb_ch ();

  heatmap_false_color_mask_unit #(.COORD_BITS(COORD_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (pix_ch),
    .out_ch      (rgb_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cfg_t      reg_shadow;
  pix_item_t pix_queue[$];
  pix_out_t  color_expect[$];
  int        n_queued;
  int        n_accepted;
  int        n_results;
  int        n_masked;
  int        n_settings;
  int        n_reg_writes;
  int        errors;
  int        src_gap;
  int        sink_wait;
  int        hold_reqs;
  int        holds_done;
  bit        src_idle_on;
  bit        snk_idle_on;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_out_t predict_pixel(input cfg_t c, input pix_item_t p);
    int hue_q;
    int frac;
    int rise;
    int fall;
    int dx;
    int dy;
    longint d2;
    logic outside_box;
    pix_out_t res;
    hue_q = ((255 - int'(p.inten)) * int'(c.hue_span) * 256 + 127) / 255;
    if (hue_q >= HUE_FULL) hue_q -= HUE_FULL;
    frac = hue_q % HUE_SECTOR;
    rise = (255 * frac + HUE_SECTOR / 2) / HUE_SECTOR;
    fall = (255 * (HUE_SECTOR - frac) + HUE_SECTOR / 2) / HUE_SECTOR;
    case (hue_q / HUE_SECTOR)
      0:       res.color = {8'd255, 8'(rise), 8'd0};
      1:       res.color = {8'(fall), 8'd255, 8'd0};
      2:       res.color = {8'd0, 8'd255, 8'(rise)};
      3:       res.color = {8'd0, 8'(fall), 8'd255};
      4:       res.color = {8'(rise), 8'd0, 8'd255};
      default: res.color = {8'd255, 8'd0, 8'(fall)};
    endcase
    res.masked = 1'b0;
    dx = int'(p.x) - int'(c.ring_cx);
    dy = int'(p.y) - int'(c.ring_cy);
    d2 = longint'(dx) * dx + longint'(dy) * dy;
    outside_box = (p.x < c.box_left) || (int'(p.x) > int'(c.box_left) + int'(c.box_width)) ||
                  (p.y < c.box_bottom) ||
                  (int'(p.y) > int'(c.box_bottom) + int'(c.box_height));
    if (d2 > longint'(c.ring_r2) && outside_box) begin
      res.color  = {MASK_RED, MASK_GREEN, MASK_BLUE};
      res.masked = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_RING_CX:   return CFG_DATA_W'(reg_shadow.ring_cx);
      REG_RING_CY:   return CFG_DATA_W'(reg_shadow.ring_cy);
      REG_RING_R2:   return CFG_DATA_W'(reg_shadow.ring_r2);
      REG_BOX_LEFT:  return CFG_DATA_W'(reg_shadow.box_left);
      REG_BOX_BOT:   return CFG_DATA_W'(reg_shadow.box_bottom);
      REG_BOX_WIDTH: return CFG_DATA_W'(reg_shadow.box_width);
      REG_BOX_HGT:   return CFG_DATA_W'(reg_shadow.box_height);
      default:       return CFG_DATA_W'(reg_shadow.hue_span);
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.ring_cx    = FIELD_COORD_W'($urandom());
    c.ring_cy    = FIELD_COORD_W'($urandom());
    c.ring_r2    = $urandom_range(0, 1) ? RADIUS_SQ_W'($urandom_range(0, 60000))
                                        : RADIUS_SQ_W'($urandom());
    c.box_left   = FIELD_COORD_W'($urandom());
    c.box_bottom = FIELD_COORD_W'($urandom());
    c.box_width  = FIELD_COORD_W'($urandom_range(0, 400));
    c.box_height = FIELD_COORD_W'($urandom());
    c.hue_span   = ($urandom_range(0, 3) == 0) ? HUE_SPAN_W'($urandom())
                                               : HUE_SPAN_W'($urandom_range(0, 359));
    return c;
  endfunction

  function automatic pix_item_t random_pixel(input cfg_t c);
    pix_item_t p;
    int reach;
    reach = $rtoi($sqrt(real'(c.ring_r2))) + 2;
    case ($urandom_range(0, 2))
      0: begin
        p.x = COORD_BITS'($urandom());
        p.y = COORD_BITS'($urandom());
      end
      1: begin
        p.x = COORD_BITS'(int'(c.ring_cx) + $urandom_range(0, 2 * reach) - reach);
        p.y = COORD_BITS'(int'(c.ring_cy) + $urandom_range(0, 2 * reach) - reach);
      end
      default: begin
        p.x = COORD_BITS'(int'(c.box_left) - 1 + $urandom_range(0, int'(c.box_width) + 2));
        p.y = COORD_BITS'(int'(c.box_bottom) - 1 + $urandom_range(0, int'(c.box_height) + 2));
      end
    endcase
    p.inten = INTENSITY_W'($urandom());
    return p;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic queue_pixel(input int x, input int y, input int inten);
    pix_item_t p;
    p.x     = COORD_BITS'(x);
    p.y     = COORD_BITS'(y);
    p.inten = INTENSITY_W'(inten);
    pix_queue = {pix_queue, p};
    n_queued++;
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] raw);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= raw;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RING_CX:   reg_shadow.ring_cx    = raw[FIELD_COORD_W-1:0];
      REG_RING_CY:   reg_shadow.ring_cy    = raw[FIELD_COORD_W-1:0];
      REG_RING_R2:   reg_shadow.ring_r2    = raw[RADIUS_SQ_W-1:0];
      REG_BOX_LEFT:  reg_shadow.box_left   = raw[FIELD_COORD_W-1:0];
      REG_BOX_BOT:   reg_shadow.box_bottom = raw[FIELD_COORD_W-1:0];
      REG_BOX_WIDTH: reg_shadow.box_width  = raw[FIELD_COORD_W-1:0];
      REG_BOX_HGT:   reg_shadow.box_height = raw[FIELD_COORD_W-1:0];
      default:       reg_shadow.hue_span   = raw[HUE_SPAN_W-1:0];
    endcase
    n_reg_writes++;
  endtask

  task automatic reg_read(input reg_idx_t idx);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== reg_value(idx)) begin
      errors++;
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, reg_value(idx),
               cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_config(input cfg_t c, input logic [CFG_DATA_W-1:0] fill);
    reg_write(REG_RING_CX,   {fill[31:10], c.ring_cx});
    reg_write(REG_RING_CY,   {fill[31:10], c.ring_cy});
    reg_write(REG_RING_R2,   {fill[31:22], c.ring_r2});
    reg_write(REG_BOX_LEFT,  {fill[31:10], c.box_left});
    reg_write(REG_BOX_BOT,   {fill[31:10], c.box_bottom});
    reg_write(REG_BOX_WIDTH, {fill[31:10], c.box_width});
    reg_write(REG_BOX_HGT,   {fill[31:10], c.box_height});
    reg_write(REG_HUE_SPAN,  {fill[31:9], c.hue_span});
    for (int i = 0; i < NUM_REGS; i++) reg_read(reg_idx_t'(i));
    n_settings++;
  endtask

  task automatic wait_pipeline_empty();
    while (n_accepted != n_queued || n_results != n_accepted) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : pix_driver
    pix_item_t nxt;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      src_gap      <= 0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (src_gap != 0) begin
        pix_ch.valid <= 1'b0;
        src_gap      <= src_gap - 1;
      end else if (pix_queue.size() != 0) begin
        nxt = pix_queue.pop_front();
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_x   <= nxt.x;
        pix_ch.pixel_y   <= nxt.y;
        pix_ch.intensity <= nxt.inten;
        src_gap          <= (src_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rgb_sink
    if (!rst_n) begin
      rgb_ch.ready <= 1'b0;
      sink_wait    <= 0;
      holds_done   <= 0;
    end else if (holds_done != hold_reqs) begin
      holds_done   <= hold_reqs;
      sink_wait    <= LONG_HOLD;
      rgb_ch.ready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait    <= sink_wait - 1;
      rgb_ch.ready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
      sink_wait    <= pick_gap() - 1;
      rgb_ch.ready <= 1'b0;
    end else begin
      rgb_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : pix_monitor
    pix_out_t  want;
    pix_item_t seen;
    if (rst_n) begin
      if (rgb_ch.valid && rgb_ch.ready) begin
        n_results++;
        if (color_expect.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected: %0d,%0d,%0d masked %0d", $time,
                   rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.masked);
        end else begin
          want = color_expect.pop_front();
          check_field("red", want.color.red, rgb_ch.red);
          check_field("green", want.color.green, rgb_ch.green);
          check_field("blue", want.color.blue, rgb_ch.blue);
          check_field("masked", 8'(want.masked), 8'(rgb_ch.masked));
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        seen.x       = pix_ch.pixel_x;
        seen.y       = pix_ch.pixel_y;
        seen.inten   = pix_ch.intensity;
        want         = predict_pixel(reg_shadow, seen);
        color_expect = {color_expect, want};
        n_accepted++;
        if (want.masked) n_masked++;
      end
    end
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_t      c;
    pix_item_t p;
    rst_n            = 1'b0;
    pix_ch.valid     = 1'b0;
    pix_ch.pixel_x   = '0;
    pix_ch.pixel_y   = '0;
    pix_ch.intensity = '0;
    rgb_ch.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    reg_shadow       = CFG_RESET;
    src_idle_on      = 1'b1;
    snk_idle_on      = 1'b1;
    hold_reqs        = 0;
    n_queued         = 0;
    n_accepted       = 0;
    n_results        = 0;
    n_masked         = 0;
    n_settings       = 1;
    n_reg_writes     = 0;
    errors           = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) reg_read(reg_idx_t'(i));

    // reset settings: ring center, box corners and edges, hue sweep
    queue_pixel(250, 250, 0);
    queue_pixel(250, 250, 255);
    queue_pixel(250, 250, 128);
    queue_pixel(250, 250, 64);
    queue_pixel(250, 250, 192);
    queue_pixel(479, 63, 100);
    queue_pixel(521, 438, 200);
    queue_pixel(522, 438, 10);
    queue_pixel(478, 100, 20);
    queue_pixel(500, 62, 30);
    queue_pixel(1023, 1023, 0);
    queue_pixel(0, 0, 255);
    wait_pipeline_empty();

    // hue of a full turn, radius boundary, single-pixel box
    c = '0;
    c.ring_cx  = 10'd500;
    c.ring_cy  = 10'd500;
    c.ring_r2  = 22'd100;
    c.hue_span = 9'd360;
    load_config(c, '0);
    queue_pixel(500, 500, 0);
    queue_pixel(506, 508, 10);
    queue_pixel(510, 501, 20);
    queue_pixel(0, 0, 30);
    queue_pixel(1, 0, 40);
    queue_pixel(0, 1, 50);
    wait_pipeline_empty();

    // every field at its maximum, hue span past a full turn
    load_config('1, '1);
    queue_pixel(0, 0, 0);
    queue_pixel(1023, 1023, 255);
    queue_pixel(512, 17, 128);
    wait_pipeline_empty();

    // zero radius and span, box edges past the coordinate range
    c = '0;
    c.box_left   = 10'd1000;
    c.box_bottom = 10'd1000;
    c.box_width  = 10'd100;
    c.box_height = 10'd100;
    load_config(c, '0);
    queue_pixel(1023, 1023, 77);
    queue_pixel(999, 1010, 1);
    queue_pixel(0, 0, 254);
    wait_pipeline_empty();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       c = '1;
        1:       c = '0;
        default: c = random_config();
      endcase
      load_config(c, (ph == 0) ? '1 : $urandom());
      src_idle_on <= (ph != NO_IDLE_PHASE && ph != HOLD_PHASE);
      snk_idle_on <= (ph != NO_IDLE_PHASE);
      if (ph == HOLD_PHASE) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        p = random_pixel(reg_shadow);
        queue_pixel(p.x, p.y, p.inten);
      end
      wait_pipeline_empty();
    end

    $display("Sent %0d pixels (%0d masked) through %0d register settings, %0d register writes,",
             n_accepted, n_masked, n_settings, n_reg_writes);
    $display("with random stalls on both channels and one long output hold.");
    if (errors == 0 && color_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hfcm_pkg.sv
rtl/hfcm_if.sv
rtl/hfcm_regs.sv
rtl/hfcm_hue.sv
rtl/hfcm_mask.sv
rtl/heatmap_false_color_mask_unit.sv
bench/heatmap_false_color_mask_unit_tb.sv
